### src/lgs_pkg.sv
`timescale 1ns / 1ps
// Package for the LED grid GRB serializer: grid geometry, frame sizes,
// command and error codes, pixel type. No dependencies.
package lgs_pkg;

    // Grid geometry
    localparam int GRID_SIDE    = 5;
    localparam int LED_TOTAL    = 25;
    localparam int BITS_PER_LED = 24;
    localparam int FRAME_BITS   = LED_TOTAL * BITS_PER_LED;
    localparam int POS_W        = $clog2(FRAME_BITS);
    localparam int COORD_W      = 8;
    localparam int IDX_W        = 16;

    // Field widths
    localparam int FUNC_W  = 3;
    localparam int COLOR_W = 8;
    localparam int DUTY_W  = 16;
    localparam int ERR_W   = 2;
    localparam int CFG_IDX_W = 1;

    // Command codes
    localparam logic [FUNC_W-1:0] FUNC_WRITE = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_FILL  = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_START = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_TICK  = 3'd4;
    localparam logic [FUNC_W-1:0] FUNC_RDERR = 3'd5;

    // Error codes
    localparam logic [ERR_W-1:0] ERR_NONE   = 2'd0;
    localparam logic [ERR_W-1:0] ERR_COORDS = 2'd1;
    localparam logic [ERR_W-1:0] ERR_BUSY   = 2'd2;

    // Configuration register indexes and reset values
    localparam logic [CFG_IDX_W-1:0] REG_ONE_DUTY  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_DUTY = 1'd1;
    localparam logic [DUTY_W-1:0]    ONE_DUTY_RST  = 16'd58;
    localparam logic [DUTY_W-1:0]    ZERO_DUTY_RST = 16'd29;

    // One pixel, packed red, green, blue
    typedef logic [3*COLOR_W-1:0] pixel_t;

endpackage

### src/led_grid_grb_pwm_serializer_top.sv
`timescale 1ns / 1ps
// Top level of the LED grid GRB serializer: pixel grid, frame shift register,
// bit counter and result register. Depends on lgs_pkg.
//
//  channel  direction  handshake           payload
//  in       to block   in_valid/in_stall   func column row red green blue
//  out      from block out_valid/out_stall duty_value duty_valid frame_last
//                                          busy_flag error_code
//  cfg      to block   cfg_we              cfg_index cfg_data
//
// Every command yields one result, registered in the output register the
// cycle after it is accepted; one transaction per cycle while out_stall stays low.
// A frame shifts out of a 600-bit shift register, one bit per tick command.
// in_stall is high only while a result is held and out_stall is high.
// rst_n clears the grid, busy, the bit counter and the error, and sets the duty values to their reset values;
// the frame shift register is loaded on each start and needs no reset.
module led_grid_grb_pwm_serializer_top
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [lgs_pkg::FUNC_W-1:0]          func,
    input  logic [lgs_pkg::COORD_W-1:0]         column,
    input  logic [lgs_pkg::COORD_W-1:0]         row,
    input  logic [lgs_pkg::COLOR_W-1:0]         red,
    input  logic [lgs_pkg::COLOR_W-1:0]         green,
    input  logic [lgs_pkg::COLOR_W-1:0]         blue,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [lgs_pkg::DUTY_W-1:0]          duty_value,
    output logic                                duty_valid,
    output logic                                frame_last,
    output logic                                busy_flag,
    output logic [lgs_pkg::ERR_W-1:0]           error_code,
    input  logic                                cfg_we,
    input  logic [lgs_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [lgs_pkg::DUTY_W-1:0]          cfg_data
);

    localparam int FB = lgs_pkg::FRAME_BITS;
    localparam int BL = lgs_pkg::BITS_PER_LED;
    localparam int CW = lgs_pkg::COLOR_W;

    logic                          in_fire;
    lgs_pkg::pixel_t               pixel_reg [lgs_pkg::LED_TOTAL];
    logic [FB-1:0]                 frame_reg;
    logic [FB-1:0]                 frame_load;
    logic [lgs_pkg::POS_W-1:0]     pos_reg;
    logic [lgs_pkg::POS_W-1:0]     pos_next;
    logic                          busy_reg;
    logic                          busy_next;
    logic [lgs_pkg::ERR_W-1:0]     err_reg;
    logic [lgs_pkg::ERR_W-1:0]     err_next;
    logic [lgs_pkg::DUTY_W-1:0]    one_duty_reg;
    logic [lgs_pkg::DUTY_W-1:0]    zero_duty_reg;
    logic                          out_valid_reg;
    logic [lgs_pkg::DUTY_W-1:0]    duty_reg;
    logic [lgs_pkg::DUTY_W-1:0]    duty_next;
    logic                          dvalid_reg;
    logic                          dvalid_next;
    logic                          last_reg;
    logic                          last_next;
    logic [lgs_pkg::ERR_W-1:0]     ecode_reg;
    logic [lgs_pkg::ERR_W-1:0]     ecode_next;
    logic                          busy_out_reg;
    logic [lgs_pkg::IDX_W-1:0]     pix_idx;
    logic                          coord_ok;
    logic                          do_write;
    logic                          do_fill;
    logic                          do_clear;
    logic                          do_load;
    logic                          do_shift;
    lgs_pkg::pixel_t               new_pixel;

    // Accept a transaction whenever the result slot is free or being drained
    assign in_stall = out_valid_reg && out_stall;
    assign in_fire  = in_valid && !in_stall;

    // Decode the pixel address and bounds check
    assign pix_idx   = lgs_pkg::IDX_W'(row) * lgs_pkg::IDX_W'(lgs_pkg::GRID_SIDE)
                     + lgs_pkg::IDX_W'(column);
    assign coord_ok  = (column < lgs_pkg::COORD_W'(lgs_pkg::GRID_SIDE))
                    && (row < lgs_pkg::COORD_W'(lgs_pkg::GRID_SIDE))
                    && (pix_idx < lgs_pkg::IDX_W'(lgs_pkg::LED_TOTAL));
    assign new_pixel = {red, green, blue};

    // Command decode, result and next state
    always_comb
    begin
        pos_next    = pos_reg;
        busy_next   = busy_reg;
        err_next    = err_reg;
        duty_next   = '0;
        dvalid_next = 1'b0;
        last_next   = 1'b0;
        ecode_next  = lgs_pkg::ERR_NONE;
        do_write    = 1'b0;
        do_fill     = 1'b0;
        do_clear    = 1'b0;
        do_load     = 1'b0;
        do_shift    = 1'b0;
        unique case (func)
            lgs_pkg::FUNC_WRITE:
            begin
                if (coord_ok)
                    do_write = 1'b1;
                else
                    err_next = lgs_pkg::ERR_COORDS;
            end
            lgs_pkg::FUNC_FILL:  do_fill  = 1'b1;
            lgs_pkg::FUNC_CLEAR: do_clear = 1'b1;
            lgs_pkg::FUNC_START:
            begin
                if (busy_reg)
                    err_next = lgs_pkg::ERR_BUSY;
                else
                begin
                    do_load   = 1'b1;
                    pos_next  = '0;
                    busy_next = 1'b1;
                end
            end
            lgs_pkg::FUNC_TICK:
            begin
                if (busy_reg)
                begin
                    do_shift    = 1'b1;
                    dvalid_next = 1'b1;
                    duty_next   = frame_reg[FB-1] ? one_duty_reg : zero_duty_reg;
                    if (pos_reg == lgs_pkg::POS_W'(FB - 1))
                    begin
                        last_next = 1'b1;
                        busy_next = 1'b0;
                        pos_next  = '0;
                    end
                    else
                        pos_next = pos_reg + lgs_pkg::POS_W'(1);
                end
            end
            lgs_pkg::FUNC_RDERR:
            begin
                ecode_next = err_reg;
                err_next   = lgs_pkg::ERR_NONE;
            end
            default: ;
        endcase
    end

    // Build the frame image in send order: per LED green, red, blue, MSB first
    generate
        for (genvar i = 0; i < lgs_pkg::LED_TOTAL; i++)
        begin : g_load
            assign frame_load[FB-1-BL*i -: BL] =
                {pixel_reg[i][CW +: CW], pixel_reg[i][2*CW +: CW], pixel_reg[i][0 +: CW]};
        end
    endgenerate

    // Pixel grid: each entry decodes its own address
    generate
        for (genvar i = 0; i < lgs_pkg::LED_TOTAL; i++)
        begin : g_pix
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    pixel_reg[i] <= '0;
                else if (in_fire)
                begin
                    if (do_clear)
                        pixel_reg[i] <= '0;
                    else if (do_fill)
                        pixel_reg[i] <= new_pixel;
                    else if (do_write && (pix_idx == lgs_pkg::IDX_W'(i)))
                        pixel_reg[i] <= new_pixel;
                end
            end
        end
    endgenerate

    // Frame shift register: load on start, advance one bit per tick
    always_ff @(posedge clk)
    begin
        if (in_fire && do_load)
            frame_reg <= frame_load;
        else if (in_fire && do_shift)
            frame_reg <= {frame_reg[FB-2:0], 1'b0};
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            busy_reg <= 1'b0;
            err_reg  <= lgs_pkg::ERR_NONE;
        end
        else if (in_fire)
        begin
            pos_reg  <= pos_next;
            busy_reg <= busy_next;
            err_reg  <= err_next;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            one_duty_reg  <= lgs_pkg::ONE_DUTY_RST;
            zero_duty_reg <= lgs_pkg::ZERO_DUTY_RST;
        end
        else if (cfg_we)
        begin
            if (cfg_index == lgs_pkg::REG_ONE_DUTY)
                one_duty_reg <= cfg_data;
            if (cfg_index == lgs_pkg::REG_ZERO_DUTY)
                zero_duty_reg <= cfg_data;
        end
    end

    // Result register: hold while stalled, drop once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_fire)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            duty_reg   <= duty_next;
            dvalid_reg <= dvalid_next;
            last_reg   <= last_next;
            ecode_reg  <= ecode_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
            busy_out_reg <= busy_next;
    end

    assign out_valid  = out_valid_reg;
    assign duty_value = duty_reg;
    assign duty_valid = dvalid_reg;
    assign frame_last = last_reg;
    assign busy_flag  = busy_out_reg;
    assign error_code = ecode_reg;

    // Checks
    a_last_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && frame_last) |-> (!busy_flag && duty_valid))
        else $error("frame_last with busy still set");

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (pos_reg <= lgs_pkg::POS_W'(FB - 1)))
        else $error("bit counter out of range");

    a_idle_pos: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> (pos_reg == '0))
        else $error("bit counter not cleared while idle");

    a_no_bit_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !duty_valid) |-> (duty_value == '0 && !frame_last))
        else $error("duty value without a transmitted bit");

    a_tick_emits: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && busy_reg && func == lgs_pkg::FUNC_TICK) |=> (out_valid && duty_valid))
        else $error("tick while busy gave no bit");

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps
// Testbench for the LED grid GRB serializer: drives commands, predicts every
// result in-house and checks it field by field. Depends on lgs_pkg and the top.
module tb_top;

    // Command codes the block ignores
    localparam logic [lgs_pkg::FUNC_W-1:0] FUNC_SPARE_6 = 3'd6;
    localparam logic [lgs_pkg::FUNC_W-1:0] FUNC_SPARE_7 = 3'd7;

    localparam int RUN_LIMIT     = 200_000;
    localparam int HOLD_OFF_LONG = 60;

    typedef struct packed {
        logic [lgs_pkg::DUTY_W-1:0] duty;
        logic                       dvalid;
        logic                       last;
        logic                       busy;
        logic [lgs_pkg::ERR_W-1:0]  err;
    } duty_result_t;

    logic                          clk;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_stall;
    logic [lgs_pkg::FUNC_W-1:0]    func;
    logic [lgs_pkg::COORD_W-1:0]   column;
    logic [lgs_pkg::COORD_W-1:0]   row;
    logic [lgs_pkg::COLOR_W-1:0]   red;
    logic [lgs_pkg::COLOR_W-1:0]   green;
    logic [lgs_pkg::COLOR_W-1:0]   blue;
    logic                          out_valid;
    logic                          out_stall;
    logic [lgs_pkg::DUTY_W-1:0]    duty_value;
    logic                          duty_valid;
    logic                          frame_last;
    logic                          busy_flag;
    logic [lgs_pkg::ERR_W-1:0]     error_code;
    logic                          cfg_we;
    logic [lgs_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [lgs_pkg::DUTY_W-1:0]    cfg_data;

    // Shadow of the block state
    lgs_pkg::pixel_t            grid_now [lgs_pkg::LED_TOTAL];
    lgs_pkg::pixel_t            frame_copy [lgs_pkg::LED_TOTAL];
    int                         tx_pos;
    bit                         tx_busy;
    logic [lgs_pkg::ERR_W-1:0]  latched_err;
    logic [lgs_pkg::DUTY_W-1:0] duty_one;
    logic [lgs_pkg::DUTY_W-1:0] duty_zero;

    duty_result_t duty_results_due [$];

    int mismatch_count;
    int cycle_count;
    int hold_left;
    int stall_left;
    bit gaps_on;
    bit stalls_on;

    led_grid_grb_pwm_serializer_top DUT
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .func       (func),
        .column     (column),
        .row        (row),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .duty_value (duty_value),
        .duty_valid (duty_valid),
        .frame_last (frame_last),
        .busy_flag  (busy_flag),
        .error_code (error_code),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always #1 clk = ~clk;

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > RUN_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Apply one command to the shadow state and return the result it yields
    function automatic duty_result_t apply_led_command(
        input logic [lgs_pkg::FUNC_W-1:0]  f,
        input logic [lgs_pkg::COORD_W-1:0] x,
        input logic [lgs_pkg::COORD_W-1:0] y,
        input logic [lgs_pkg::COLOR_W-1:0] r,
        input logic [lgs_pkg::COLOR_W-1:0] g,
        input logic [lgs_pkg::COLOR_W-1:0] b
    );
        duty_result_t                res;
        int                          led;
        int                          bit_in_led;
        int                          chan;
        int                          bitn;
        logic [lgs_pkg::COLOR_W-1:0] colour;
        lgs_pkg::pixel_t             px;
        res = '0;
        case (f)
            lgs_pkg::FUNC_WRITE:
                if (x >= lgs_pkg::GRID_SIDE || y >= lgs_pkg::GRID_SIDE)
                    latched_err = lgs_pkg::ERR_COORDS;
                else
                    grid_now[y * lgs_pkg::GRID_SIDE + x] = {r, g, b};
            lgs_pkg::FUNC_FILL:
                foreach (grid_now[i])
                    grid_now[i] = {r, g, b};
            lgs_pkg::FUNC_CLEAR:
                foreach (grid_now[i])
                    grid_now[i] = '0;
            lgs_pkg::FUNC_START:
                if (tx_busy)
                    latched_err = lgs_pkg::ERR_BUSY;
                else
                begin
                    frame_copy = grid_now;
                    tx_pos     = 0;
                    tx_busy    = 1'b1;
                end
            lgs_pkg::FUNC_TICK:
                if (tx_busy)
                begin
                    // green, red, blue per LED, MSB first
                    led        = tx_pos / lgs_pkg::BITS_PER_LED;
                    bit_in_led = tx_pos % lgs_pkg::BITS_PER_LED;
                    chan       = bit_in_led / lgs_pkg::COLOR_W;
                    bitn       = lgs_pkg::COLOR_W - 1 - bit_in_led % lgs_pkg::COLOR_W;
                    px         = frame_copy[led];
                    if (chan == 0)
                        colour = px[15:8];
                    else if (chan == 1)
                        colour = px[23:16];
                    else
                        colour = px[7:0];
                    res.duty   = colour[bitn] ? duty_one : duty_zero;
                    res.dvalid = 1'b1;
                    if (tx_pos + 1 >= lgs_pkg::FRAME_BITS)
                    begin
                        res.last = 1'b1;
                        tx_busy  = 1'b0;
                        tx_pos   = 0;
                    end
                    else
                        tx_pos++;
                end
            lgs_pkg::FUNC_RDERR:
            begin
                res.err     = latched_err;
                latched_err = lgs_pkg::ERR_NONE;
            end
            default: ;
        endcase
        res.busy = tx_busy;
        return res;
    endfunction

    // Offer one transaction after a random gap; predict it once accepted
    task automatic send_cmd(
        input logic [lgs_pkg::FUNC_W-1:0]  f,
        input logic [lgs_pkg::COORD_W-1:0] x,
        input logic [lgs_pkg::COORD_W-1:0] y,
        input logic [lgs_pkg::COLOR_W-1:0] r,
        input logic [lgs_pkg::COLOR_W-1:0] g,
        input logic [lgs_pkg::COLOR_W-1:0] b
    );
        int gap;
        gap = gaps_on ? $urandom_range(0, 3) : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        func     <= f;
        column   <= x;
        row      <= y;
        red      <= r;
        green    <= g;
        blue     <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        duty_results_due.push_back(apply_led_command(f, x, y, r, g, b));
    endtask

    task automatic send_tick();
        logic [lgs_pkg::COORD_W-1:0] x;
        logic [lgs_pkg::COORD_W-1:0] y;
        logic [lgs_pkg::COLOR_W-1:0] r;
        logic [lgs_pkg::COLOR_W-1:0] g;
        logic [lgs_pkg::COLOR_W-1:0] b;
        x = lgs_pkg::COORD_W'($urandom);
        y = lgs_pkg::COORD_W'($urandom);
        r = lgs_pkg::COLOR_W'($urandom);
        g = lgs_pkg::COLOR_W'($urandom);
        b = lgs_pkg::COLOR_W'($urandom);
        send_cmd(lgs_pkg::FUNC_TICK, x, y, r, g, b);
    endtask

    // Draw one command of any kind; start frame only where allowed
    task automatic send_random_cmd(input bit allow_start);
        int                          pick;
        logic [lgs_pkg::FUNC_W-1:0]  f;
        logic [lgs_pkg::COORD_W-1:0] x;
        logic [lgs_pkg::COORD_W-1:0] y;
        logic [lgs_pkg::COLOR_W-1:0] r;
        logic [lgs_pkg::COLOR_W-1:0] g;
        logic [lgs_pkg::COLOR_W-1:0] b;
        pick = $urandom_range(0, 99);
        x = lgs_pkg::COORD_W'($urandom);
        y = lgs_pkg::COORD_W'($urandom);
        r = lgs_pkg::COLOR_W'($urandom);
        g = lgs_pkg::COLOR_W'($urandom);
        b = lgs_pkg::COLOR_W'($urandom);
        if (pick < 30)
        begin
            f = lgs_pkg::FUNC_WRITE;
            x = lgs_pkg::COORD_W'($urandom_range(0, lgs_pkg::GRID_SIDE - 1));
            y = lgs_pkg::COORD_W'($urandom_range(0, lgs_pkg::GRID_SIDE - 1));
        end
        else if (pick < 40)
            f = lgs_pkg::FUNC_WRITE;
        else if (pick < 50)
            f = lgs_pkg::FUNC_FILL;
        else if (pick < 56)
            f = lgs_pkg::FUNC_CLEAR;
        else if (pick < 70)
            f = lgs_pkg::FUNC_RDERR;
        else if (pick < 80)
            f = lgs_pkg::FUNC_TICK;
        else if (pick < 86)
            f = FUNC_SPARE_6;
        else if (pick < 92)
            f = FUNC_SPARE_7;
        else
            f = allow_start ? lgs_pkg::FUNC_START : lgs_pkg::FUNC_RDERR;
        send_cmd(f, x, y, r, g, b);
    endtask

    // Drop valid and hold until every predicted result has come back
    task automatic wait_results_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (duty_results_due.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_duty_reg(input logic [lgs_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [lgs_pkg::DUTY_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == lgs_pkg::REG_ONE_DUTY)
            duty_one = val;
        else
            duty_zero = val;
    endtask

    // Tick the frame in flight to its end, mixing in other commands
    task automatic finish_frame(input int noise_pct);
        int sent;
        sent = 0;
        while (tx_busy)
        begin
            if (sent % 100 == 0)
            begin
                gaps_on   = 1'($urandom_range(0, 1));
                stalls_on = 1'($urandom_range(0, 1));
            end
            if ($urandom_range(0, 99) < noise_pct)
                send_random_cmd(1'b1);
            else
                send_tick();
            sent++;
        end
    endtask

    // Edit the grid at random, then start a frame
    task automatic begin_random_frame();
        int n;
        n = $urandom_range(6, 16);
        repeat (n) send_random_cmd(1'b0);
        send_cmd(lgs_pkg::FUNC_START,
                 lgs_pkg::COORD_W'($urandom), lgs_pkg::COORD_W'($urandom),
                 lgs_pkg::COLOR_W'($urandom), lgs_pkg::COLOR_W'($urandom),
                 lgs_pkg::COLOR_W'($urandom));
    endtask

    // Grid edits, coordinate errors, error read-back, idle tick, spare codes
    task automatic test_grid_commands();
        send_cmd(lgs_pkg::FUNC_TICK,  8'd0,   8'd0,   8'h00, 8'h00, 8'h00);
        send_cmd(lgs_pkg::FUNC_RDERR, 8'd0,   8'd0,   8'h00, 8'h00, 8'h00);
        send_cmd(lgs_pkg::FUNC_WRITE, 8'd0,   8'd0,   8'hFF, 8'hFF, 8'hFF);
        send_cmd(lgs_pkg::FUNC_WRITE, 8'd4,   8'd4,   8'h00, 8'hA5, 8'h5A);
        send_cmd(lgs_pkg::FUNC_WRITE, 8'd5,   8'd0,   8'h11, 8'h22, 8'h33);
        send_cmd(lgs_pkg::FUNC_WRITE, 8'd0,   8'd5,   8'h11, 8'h22, 8'h33);
        send_cmd(lgs_pkg::FUNC_WRITE, 8'd255, 8'd255, 8'hFF, 8'hFF, 8'hFF);
        send_cmd(lgs_pkg::FUNC_RDERR, 8'd0,   8'd0,   8'h00, 8'h00, 8'h00);
        send_cmd(lgs_pkg::FUNC_RDERR, 8'd0,   8'd0,   8'h00, 8'h00, 8'h00);
        send_cmd(lgs_pkg::FUNC_FILL,  8'd0,   8'd0,   8'h12, 8'h34, 8'h56);
        send_cmd(lgs_pkg::FUNC_CLEAR, 8'd0,   8'd0,   8'hFF, 8'hFF, 8'hFF);
        send_cmd(FUNC_SPARE_6,        8'd3,   8'd3,   8'hFF, 8'hFF, 8'hFF);
        send_cmd(FUNC_SPARE_7,        8'd1,   8'd1,   8'hFF, 8'hFF, 8'hFF);
        send_cmd(lgs_pkg::FUNC_WRITE, 8'd2,   8'd3,   8'h80, 8'h01, 8'hFF);
        send_cmd(lgs_pkg::FUNC_WRITE, 8'd4,   8'd0,   8'hFF, 8'h00, 8'h80);
        send_cmd(lgs_pkg::FUNC_WRITE, 8'd0,   8'd4,   8'h01, 8'h7F, 8'hC3);
    endtask

    // Start, start while busy, edits while busy, first bits, busy error
    task automatic test_frame_start();
        send_cmd(lgs_pkg::FUNC_START, 8'd0, 8'd0, 8'h00, 8'h00, 8'h00);
        send_cmd(lgs_pkg::FUNC_START, 8'd0, 8'd0, 8'h00, 8'h00, 8'h00);
        send_cmd(lgs_pkg::FUNC_WRITE, 8'd0, 8'd0, 8'hAA, 8'h55, 8'hAA);
        send_cmd(lgs_pkg::FUNC_FILL,  8'd0, 8'd0, 8'hFF, 8'hFF, 8'hFF);
        repeat (6) send_tick();
        send_cmd(lgs_pkg::FUNC_RDERR, 8'd0, 8'd0, 8'h00, 8'h00, 8'h00);
    endtask

    // Hold off the receiver so the block stalls its input, then pause sending
    task automatic test_backpressure();
        gaps_on   = 1'b0;
        hold_left = HOLD_OFF_LONG;
        repeat (20) send_tick();
        wait_results_drained();
        repeat (10) send_tick();
    endtask

    task automatic test_duty_setting(input logic [lgs_pkg::DUTY_W-1:0] one_val,
                                     input logic [lgs_pkg::DUTY_W-1:0] zero_val);
        wait_results_drained();
        write_duty_reg(lgs_pkg::REG_ONE_DUTY, one_val);
        write_duty_reg(lgs_pkg::REG_ZERO_DUTY, zero_val);
        begin_random_frame();
        finish_frame(6);
    endtask

    // Check the oldest prediction against each result transaction
    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            mismatch_count++;
            $display("%0t: %s expected %0h, actual %0h", $time, what, want, got);
        end
    endtask

    always @(posedge clk)
    begin : result_check
        duty_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            stall_left = stalls_on ? $urandom_range(0, 3) : 0;
            if (duty_results_due.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: result expected none, actual duty %0h", $time, duty_value);
            end
            else
            begin
                want = duty_results_due.pop_front();
                check_field("duty_value", 32'(want.duty), 32'(duty_value));
                check_field("duty_valid", 32'(want.dvalid), 32'(duty_valid));
                check_field("frame_last", 32'(want.last), 32'(frame_last));
                check_field("busy_flag", 32'(want.busy), 32'(busy_flag));
                check_field("error_code", 32'(want.err), 32'(error_code));
            end
        end
    end

    // Receiver: long hold-off on request, else a short random stall per result
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    initial
    begin
        clk         = 1'b0;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        func        = lgs_pkg::FUNC_TICK;
        column      = '0;
        row         = '0;
        red         = '0;
        green       = '0;
        blue        = '0;
        out_stall   = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = lgs_pkg::REG_ONE_DUTY;
        cfg_data    = '0;
        foreach (grid_now[i])
            grid_now[i] = '0;
        foreach (frame_copy[i])
            frame_copy[i] = '0;
        tx_pos         = 0;
        tx_busy        = 1'b0;
        latched_err    = lgs_pkg::ERR_NONE;
        duty_one       = lgs_pkg::ONE_DUTY_RST;
        duty_zero      = lgs_pkg::ZERO_DUTY_RST;
        mismatch_count = 0;
        cycle_count    = 0;
        hold_left      = 0;
        stall_left     = 0;
        gaps_on        = 1'b1;
        stalls_on      = 1'b1;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_grid_commands();
        test_frame_start();
        test_backpressure();
        finish_frame(5);
        test_duty_setting(16'hFFFF, 16'h0000);
        test_duty_setting(16'h0000, 16'hFFFF);

        // random duties, then leave a frame in flight
        wait_results_drained();
        write_duty_reg(lgs_pkg::REG_ONE_DUTY, lgs_pkg::DUTY_W'($urandom));
        write_duty_reg(lgs_pkg::REG_ZERO_DUTY, lgs_pkg::DUTY_W'($urandom));
        begin_random_frame();
        repeat (40) send_random_cmd(1'b1);

        wait_results_drained();
        repeat (4) @(posedge clk);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
